@@ rtl/core/csct_pkg.sv @@
// Shared constants and types for the capsule segment collision test.
package csct_pkg;

  localparam int COORD_WIDTH = 24;

  typedef enum logic [1:0] {
    REG_START,
    REG_END,
    REG_INTERIOR
  } seg_region_t;

  typedef struct packed {
    logic hit;
    logic cneg;
    logic czero;
  } lane_flags_t;

endpackage

@@ rtl/core/csct_lane.sv @@
// One point-to-segment lane: squared distance, shift-add square root, radius test.
module csct_lane #(
  parameter int W = csct_pkg::COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  px,
  input  logic signed [W-1:0]  py,
  input  logic signed [W-1:0]  ax,
  input  logic signed [W-1:0]  ay,
  input  logic signed [W-1:0]  bx,
  input  logic signed [W-1:0]  by,
  input  logic        [W-1:0]  rsum,
  output logic                 out_valid,
  output logic        [W-1:0]  q,
  output csct_pkg::lane_flags_t flags
);
  import csct_pkg::*;

  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NW = 2 * SW;
  localparam int QW = W + SW;
  localparam int CW = NW + 1;
  localparam int LW = SW / 2;
  localparam int HW = SW - LW;

  // stage A: differences
  logic                 va;
  logic signed [DW-1:0] a_vx, a_vy, a_wx, a_wy, a_ux, a_uy;
  logic        [W-1:0]  a_r;
  // stage B: products
  logic                 vb;
  logic signed [PW-1:0] b_vxwy, b_vywx, b_wxvx, b_wyvy, b_vxvx, b_vyvy;
  logic signed [PW-1:0] b_wxwx, b_wywy, b_uxux, b_uyuy;
  logic        [W-1:0]  b_r;
  // stage C: cross, projection, lengths
  logic                 vc;
  logic signed [SW-1:0] c_c, c_proj, c_len2, c_dw, c_du;
  logic        [W-1:0]  c_r;
  // stage D: region select, square of cross split in parts
  logic                 vd;
  seg_region_t          d_region;
  logic        [SW-1:0] d_len2, d_dw, d_du;
  logic      [2*HW-1:0] d_hh;
  logic     [HW+LW-1:0] d_hl;
  logic      [2*LW-1:0] d_ll;
  logic                 d_cneg, d_cz;
  logic        [W-1:0]  d_r;

  seg_region_t          region;
  logic        [SW-1:0] cmag;

  // square root pipeline, entry 0 is the num/den stage
  logic                 s_v    [0:W];
  logic        [W-1:0]  s_q    [0:W];
  logic        [NW-1:0] s_p    [0:W];
  logic        [QW-1:0] s_qd   [0:W];
  logic        [NW-1:0] s_num  [0:W];
  logic        [SW-1:0] s_den  [0:W];
  logic        [W-1:0]  s_r    [0:W];
  logic                 s_cneg [0:W];
  logic                 s_cz   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      s_v[0] <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
      s_v[0] <= vd;
    end
  end

  always_comb begin
    cmag = c_c[SW-1] ? SW'(-c_c) : SW'(c_c);
    if (c_proj <= 0) begin
      region = REG_START;
    end else if (c_len2 <= c_proj) begin
      region = REG_END;
    end else begin
      region = REG_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_vx <= DW'(bx) - DW'(ax);
      a_vy <= DW'(by) - DW'(ay);
      a_wx <= DW'(px) - DW'(ax);
      a_wy <= DW'(py) - DW'(ay);
      a_ux <= DW'(px) - DW'(bx);
      a_uy <= DW'(py) - DW'(by);
      a_r  <= rsum;

      b_vxwy <= a_vx * a_wy;
      b_vywx <= a_vy * a_wx;
      b_wxvx <= a_wx * a_vx;
      b_wyvy <= a_wy * a_vy;
      b_vxvx <= a_vx * a_vx;
      b_vyvy <= a_vy * a_vy;
      b_wxwx <= a_wx * a_wx;
      b_wywy <= a_wy * a_wy;
      b_uxux <= a_ux * a_ux;
      b_uyuy <= a_uy * a_uy;
      b_r    <= a_r;

      c_c    <= SW'(b_vxwy) - SW'(b_vywx);
      c_proj <= SW'(b_wxvx) + SW'(b_wyvy);
      c_len2 <= SW'(b_vxvx) + SW'(b_vyvy);
      c_dw   <= SW'(b_wxwx) + SW'(b_wywy);
      c_du   <= SW'(b_uxux) + SW'(b_uyuy);
      c_r    <= b_r;

      d_region <= region;
      d_len2   <= SW'(c_len2);
      d_dw     <= SW'(c_dw);
      d_du     <= SW'(c_du);
      d_hh     <= (2*HW)'(cmag[SW-1:LW]) * (2*HW)'(cmag[SW-1:LW]);
      d_hl     <= (HW+LW)'(cmag[SW-1:LW]) * (HW+LW)'(cmag[LW-1:0]);
      d_ll     <= (2*LW)'(cmag[LW-1:0]) * (2*LW)'(cmag[LW-1:0]);
      d_cneg   <= c_c[SW-1];
      d_cz     <= (c_c == '0);
      d_r      <= c_r;

      case (d_region)
        REG_START: begin
          s_num[0] <= NW'(d_dw);
          s_den[0] <= SW'(1);
        end
        REG_END: begin
          s_num[0] <= NW'(d_du);
          s_den[0] <= SW'(1);
        end
        default: begin
          s_num[0] <= (NW'(d_hh) << (2*LW)) + (NW'(d_hl) << (LW+1)) + NW'(d_ll);
          s_den[0] <= d_len2;
        end
      endcase
      s_q[0]    <= '0;
      s_p[0]    <= '0;
      s_qd[0]   <= '0;
      s_r[0]    <= d_r;
      s_cneg[0] <= d_cneg;
      s_cz[0]   <= d_cz;
    end
  end

  // stage k settles result bit W-k using running q^2*den and q*den
  for (genvar k = 1; k <= W; k++) begin : g_root
    localparam int BI = W - k;
    logic [CW-1:0] cand;
    logic          take;

    always_comb begin
      cand = CW'(s_p[k-1]) + (CW'(s_qd[k-1]) << (BI+1)) + (CW'(s_den[k-1]) << (2*BI));
      take = (cand <= CW'(s_num[k-1]));
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[k] <= 1'b0;
      end else if (en) begin
        s_v[k] <= s_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[k]    <= take ? (s_q[k-1] | (W'(1) << BI)) : s_q[k-1];
        s_p[k]    <= take ? NW'(cand) : s_p[k-1];
        s_qd[k]   <= take ? (s_qd[k-1] + (QW'(s_den[k-1]) << BI)) : s_qd[k-1];
        s_num[k]  <= s_num[k-1];
        s_den[k]  <= s_den[k-1];
        s_r[k]    <= s_r[k-1];
        s_cneg[k] <= s_cneg[k-1];
        s_cz[k]   <= s_cz[k-1];
      end
    end
  end

  // exact test: dist <= R iff floor root below R, or equal with zero remainder
  assign out_valid   = s_v[W];
  assign q           = s_q[W];
  assign flags.hit   = (s_q[W] < s_r[W]) || ((s_q[W] == s_r[W]) && (s_p[W] == s_num[W]));
  assign flags.cneg  = s_cneg[W];
  assign flags.czero = s_cz[W];

endmodule

@@ rtl/core/capsule_segment_collision_test.sv @@
// Top level of the capsule segment collision test pipeline.
// Takes one segment pair per cycle while not stalled and returns its exact closest distance
// (floor, saturated) and the capsule hit flag after five stages of differences, products,
// sums and squared-distance setup, one stage per result bit in the shift-add square root, and
// the output register that takes the least of the four endpoint-to-segment lanes. A result
// not taken stalls the whole pipeline in place; in_ready is low only while the output
// register holds an untaken transaction.
module capsule_segment_collision_test #(
  parameter int COORD_WIDTH = csct_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_start_x,
  input  logic signed [COORD_WIDTH-1:0] first_start_y,
  input  logic signed [COORD_WIDTH-1:0] first_end_x,
  input  logic signed [COORD_WIDTH-1:0] first_end_y,
  input  logic signed [COORD_WIDTH-1:0] second_start_x,
  input  logic signed [COORD_WIDTH-1:0] second_start_y,
  input  logic signed [COORD_WIDTH-1:0] second_end_x,
  input  logic signed [COORD_WIDTH-1:0] second_end_y,
  input  logic        [COORD_WIDTH-2:0] first_radius,
  input  logic        [COORD_WIDTH-2:0] second_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [COORD_WIDTH-1:0] closest_distance,
  output logic                          hit
);
  import csct_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                en;
  logic [W-1:0]        rsum;
  logic [3:0]          lane_valid;
  logic [W-1:0]        lane_q [0:3];
  lane_flags_t         lane_flags [0:3];
  logic [W-1:0]        m01, m23, qmin;
  logic                crossing;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign rsum     = W'(first_radius) + W'(second_radius);

  csct_lane #(.W(W)) u_lane0 (
    .clk, .rst, .en, .in_valid,
    .px(second_start_x), .py(second_start_y),
    .ax(first_start_x), .ay(first_start_y), .bx(first_end_x), .by(first_end_y),
    .rsum, .out_valid(lane_valid[0]), .q(lane_q[0]), .flags(lane_flags[0])
  );

  csct_lane #(.W(W)) u_lane1 (
    .clk, .rst, .en, .in_valid,
    .px(second_end_x), .py(second_end_y),
    .ax(first_start_x), .ay(first_start_y), .bx(first_end_x), .by(first_end_y),
    .rsum, .out_valid(lane_valid[1]), .q(lane_q[1]), .flags(lane_flags[1])
  );

  csct_lane #(.W(W)) u_lane2 (
    .clk, .rst, .en, .in_valid,
    .px(first_start_x), .py(first_start_y),
    .ax(second_start_x), .ay(second_start_y), .bx(second_end_x), .by(second_end_y),
    .rsum, .out_valid(lane_valid[2]), .q(lane_q[2]), .flags(lane_flags[2])
  );

  csct_lane #(.W(W)) u_lane3 (
    .clk, .rst, .en, .in_valid,
    .px(first_end_x), .py(first_end_y),
    .ax(second_start_x), .ay(second_start_y), .bx(second_end_x), .by(second_end_y),
    .rsum, .out_valid(lane_valid[3]), .q(lane_q[3]), .flags(lane_flags[3])
  );

  // proper crossing: each segment's endpoints strictly on opposite sides of the other
  always_comb begin
    crossing = !lane_flags[0].czero && !lane_flags[1].czero &&
               (lane_flags[0].cneg != lane_flags[1].cneg) &&
               !lane_flags[2].czero && !lane_flags[3].czero &&
               (lane_flags[2].cneg != lane_flags[3].cneg);
    m01  = (lane_q[0] < lane_q[1]) ? lane_q[0] : lane_q[1];
    m23  = (lane_q[2] < lane_q[3]) ? lane_q[2] : lane_q[3];
    qmin = (m01 < m23) ? m01 : m23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= lane_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      closest_distance <= crossing ? '0 : qmin;
      hit <= crossing || lane_flags[0].hit || lane_flags[1].hit ||
             lane_flags[2].hit || lane_flags[3].hit;
    end
  end

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    lane_valid == 4'b0000 || lane_valid == 4'b1111)
    else $error("lane valid bits out of step");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(closest_distance) && $stable(hit))
    else $error("untaken result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

@@ test/capsule_segment_collision_test_test.sv @@
// Self-checking testbench for the capsule segment collision test pipeline.
module capsule_segment_collision_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = csct_pkg::COORD_WIDTH;
  localparam int LATENCY = CW + 6;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CW-1:0] SAT = '1;
  localparam logic [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NMAX = {1'b1, {(CW-1){1'b0}}};

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] c[8];
    logic [CW-2:0] r1, r2;
    bit known;
    logic [CW-1:0] want_span;
    logic want_hit;
  } pair_t;

  typedef struct {
    logic [CW-1:0] span;
    logic hit;
  } outcome_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [CW-1:0] coord[8];
  logic [CW-2:0] first_radius = 0, second_radius = 0;
  logic out_valid, out_ready = 0;
  logic [CW-1:0] closest_distance;
  logic hit;

  outcome_t pending[$];
  int errors = 0, cycles = 0, accepted = 0, hits = 0;
  int send_idle = 0, recv_stall = 0, hold = 0;
  bit long_hold = 0, long_hold_done = 0;

  initial for (int i = 0; i < 8; i++) coord[i] = '0;

  always #5 clk = ~clk;

  capsule_segment_collision_test uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .first_start_x(coord[0]), .first_start_y(coord[1]),
    .first_end_x(coord[2]), .first_end_y(coord[3]),
    .second_start_x(coord[4]), .second_start_y(coord[5]),
    .second_end_x(coord[6]), .second_end_y(coord[7]),
    .first_radius(first_radius), .second_radius(second_radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .closest_distance(closest_distance), .hit(hit)
  );

  // squared distance from p to segment a-b as num/den
  function automatic void point_to_segment(wide_t px, wide_t py, wide_t ax, wide_t ay,
                                           wide_t bx, wide_t by,
                                           output wide_t num, output wide_t den);
    wide_t vx, vy, wx, wy, proj, len2, c;
    vx = bx - ax; vy = by - ay; wx = px - ax; wy = py - ay;
    proj = wx * vx + wy * vy;
    len2 = vx * vx + vy * vy;
    if (proj <= 0) begin
      num = wx * wx + wy * wy; den = 1;
    end else if (len2 <= proj) begin
      num = (px - bx) * (px - bx) + (py - by) * (py - by); den = 1;
    end else begin
      c = vx * wy - vy * wx;
      num = c * c; den = len2;
    end
  endfunction

  function automatic outcome_t closest_approach(pair_t s);
    wide_t p[8];
    wide_t c1, c2, c3, c4, num, den, n2, d2, rsum, tw;
    logic [CW-1:0] q, t;
    outcome_t o;
    for (int i = 0; i < 8; i++) p[i] = s.c[i];
    rsum = s.r1;
    rsum = rsum + wide_t'(s.r2);
    c1 = (p[2] - p[0]) * (p[5] - p[1]) - (p[3] - p[1]) * (p[4] - p[0]);
    c2 = (p[2] - p[0]) * (p[7] - p[1]) - (p[3] - p[1]) * (p[6] - p[0]);
    c3 = (p[6] - p[4]) * (p[1] - p[5]) - (p[7] - p[5]) * (p[0] - p[4]);
    c4 = (p[6] - p[4]) * (p[3] - p[5]) - (p[7] - p[5]) * (p[2] - p[4]);
    if (c1 * c2 < 0 && c3 * c4 < 0) begin
      num = 0; den = 1;
    end else begin
      point_to_segment(p[4], p[5], p[0], p[1], p[2], p[3], num, den);
      for (int i = 1; i < 4; i++) begin
        case (i)
          1: point_to_segment(p[6], p[7], p[0], p[1], p[2], p[3], n2, d2);
          2: point_to_segment(p[0], p[1], p[4], p[5], p[6], p[7], n2, d2);
          default: point_to_segment(p[2], p[3], p[4], p[5], p[6], p[7], n2, d2);
        endcase
        if (!(num * d2 <= n2 * den)) begin
          num = n2; den = d2;
        end
      end
    end
    q = '0;
    for (int i = CW - 1; i >= 0; i--) begin
      t = q | (CW'(1) << i);
      tw = {{(256-CW){1'b0}}, t};
      if (tw * tw * den <= num) q = t;
    end
    o.span = q;
    o.hit = (num <= rsum * rsum * den);
    return o;
  endfunction

  task automatic offer(pair_t s);
    outcome_t o;
    while ($urandom_range(99) < send_idle) begin
      in_valid = 0;
      @(negedge clk);
    end
    for (int i = 0; i < 8; i++) coord[i] = s.c[i];
    first_radius = s.r1;
    second_radius = s.r2;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    if (s.known) begin
      o.span = s.want_span; o.hit = s.want_hit;
    end else o = closest_approach(s);
    pending.push_back(o);
    accepted++;
    if (o.hit) hits++;
    @(negedge clk);
  endtask

  function automatic pair_t make_pair(int ax, int ay, int bx, int by, int cx, int cy,
                                      int dx, int dy, int r1, int r2);
    pair_t s;
    s.c[0] = CW'(ax); s.c[1] = CW'(ay); s.c[2] = CW'(bx); s.c[3] = CW'(by);
    s.c[4] = CW'(cx); s.c[5] = CW'(cy); s.c[6] = CW'(dx); s.c[7] = CW'(dy);
    s.r1 = (CW-1)'(r1); s.r2 = (CW-1)'(r2);
    s.known = 0; s.want_span = 0; s.want_hit = 0;
    return s;
  endfunction

  function automatic pair_t typed(pair_t s, logic [CW-1:0] span, logic h);
    s.known = 1; s.want_span = span; s.want_hit = h;
    return s;
  endfunction

  function automatic pair_t random_pair();
    pair_t s;
    int kind, span, base;
    kind = int'($urandom_range(9));
    span = (kind < 5) ? 2048 : 8388607;
    for (int i = 0; i < 8; i++) begin
      if (kind == 9) s.c[i] = CW'($urandom);
      else s.c[i] = CW'(int'($urandom_range(2 * span)) - span);
    end
    if (kind == 5) begin
      s.c[2] = s.c[0]; s.c[3] = s.c[1];
    end else if (kind == 6) begin
      base = int'($urandom_range(512));
      s.c[1] = CW'(base); s.c[3] = CW'(base); s.c[5] = CW'(base); s.c[7] = CW'(base);
    end else if (kind == 7) begin
      s.c[4] = s.c[2]; s.c[5] = s.c[3];
    end
    if ($urandom_range(3) == 0) begin
      s.r1 = (CW-1)'($urandom); s.r2 = (CW-1)'($urandom);
    end else begin
      s.r1 = (CW-1)'($urandom_range(1024)); s.r2 = (CW-1)'($urandom_range(1024));
    end
    s.known = 0; s.want_span = 0; s.want_hit = 0;
    return s;
  endfunction

  always @(negedge clk) begin
    if (long_hold && !long_hold_done) begin
      long_hold_done <= 1;
      hold <= 3 * LATENCY;
      out_ready <= 0;
    end else if (hold > 0) begin
      out_ready <= 0;
      hold <= hold - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d transactions outstanding", $time, pending.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t unexpected transaction: distance %0d hit %0b",
                 $time, closest_distance, hit);
        errors++;
      end else begin
        outcome_t e;
        e = pending.pop_front();
        if (closest_distance !== e.span || hit !== e.hit) begin
          $display("%0t mismatch: expected distance %0d hit %0b, got distance %0d hit %0b",
                   $time, e.span, e.hit, closest_distance, hit);
          errors++;
        end
      end
    end
  end

  initial begin
    pair_t table_rows[$];
    table_rows.push_back(typed(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1));
    table_rows.push_back(typed(make_pair(-256, 0, 256, 0, 0, -256, 0, 256, 0, 0), 0, 1));
    table_rows.push_back(typed(make_pair(0, 0, 256, 0, 0, 256, 256, 256, 0, 0), 256, 0));
    table_rows.push_back(typed(make_pair(0, 0, 256, 0, 0, 256, 256, 256, 128, 128), 256, 1));
    table_rows.push_back(typed(make_pair(0, 0, 256, 0, 0, 256, 256, 256, 128, 127), 256, 0));
    table_rows.push_back(typed(make_pair(NMAX, NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, PMAX,
                                         0, 0), SAT, 0));
    table_rows.push_back(typed(make_pair(NMAX, NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, PMAX,
                                         8388607, 8388607), SAT, 0));
    table_rows.push_back(typed(make_pair(128, 0, 128, 0, 0, 0, 256, 0, 0, 0), 0, 1));
    table_rows.push_back(typed(make_pair(0, 0, 512, 0, 256, 0, 768, 0, 0, 0), 0, 1));
    table_rows.push_back(typed(make_pair(0, 0, 256, 0, 256, 0, 256, 256, 0, 0), 0, 1));
    table_rows.push_back(typed(make_pair(0, 0, 0, 0, 768, 1024, 768, 1024, 0, 0), 1280, 0));
    table_rows.push_back(make_pair(0, 0, 256, 0, 512, -100, 512, 300, 10, 20));
    table_rows.push_back(make_pair(0, 0, 256, 256, 300, 0, 900, 10, 300, 0));
    table_rows.push_back(make_pair(NMAX, PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, PMAX,
                                   8388607, 0));
    table_rows.push_back(make_pair(PMAX, PMAX, PMAX, 0, NMAX, 0, 0, 0, 0, 8388607));
    table_rows.push_back(make_pair(-1, -1, 1, 1, 1, -1, 3, 1, 1, 0));
    table_rows.push_back(make_pair(100, 7, 100, 7, 0, 0, 300, 21, 0, 0));
    table_rows.push_back(make_pair(0, 0, 1000, 1, 0, 3, 1000, 4, 1, 1));

    repeat (7) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    foreach (table_rows[i]) offer(table_rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      in_valid = 0;
      wait (pending.size() == 0);
      @(negedge clk);
      send_idle = (ph == 1) ? 50 : (ph == 3) ? 15 : 0;
      recv_stall = (ph == 2) ? 50 : (ph == 3) ? 15 : 0;
      if (ph == 0) long_hold = 1;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) offer(random_pair());
    end
    in_valid = 0;

    wait (pending.size() == 0);
    repeat (2 * LATENCY) @(posedge clk);
    $display("Checked %0d segment pairs (%0d capsule hits) over four handshake phases,",
             accepted, hits);
    $display("including crossings, degenerate points, collinear overlap and saturation.");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/csct_pkg.sv
rtl/core/csct_lane.sv
rtl/core/capsule_segment_collision_test.sv
test/capsule_segment_collision_test_test.sv
